>>> rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the framed packet receiver
// Field widths of the receive and packet words, and the frame marker bytes.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 16;
  localparam int FUNC_W  = 16;
  localparam int LEN_W   = 7;
  localparam int INDEX_W = 6;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'h3a;
  localparam logic [BYTE_W-1:0] CR_BYTE    = 8'h0d;
  localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0a;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [INDEX_W-1:0] index_t;

endpackage

>>> rtl/fpr_if.sv
// ----------------------------------------------------------------------------
// fpr_if: channel interfaces of the framed packet receiver
// Receive byte channel and packet word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpr_rx_if;
  logic          valid;
  logic          ready;
  fpr_pkg::byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpr_pkt_if;
  logic            valid;
  logic            ready;
  fpr_pkg::addr_t  pkt_address;
  fpr_pkg::func_t  pkt_function;
  fpr_pkg::len_t   pkt_length;
  logic            has_payload;
  fpr_pkg::index_t payload_index;
  fpr_pkg::byte_t  payload_byte;
  logic            last;

  modport source (output valid, output pkt_address, output pkt_function,
                  output pkt_length, output has_payload, output payload_index,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input pkt_address, input pkt_function,
                  input pkt_length, input has_payload, input payload_index,
                  input payload_byte, input last, output ready);
endinterface

>>> rtl/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/framed_packet_receiver.sv
// ----------------------------------------------------------------------------
// framed_packet_receiver: colon / CR LF framed binary packet receiver
// Parses framed packets from a byte stream and replays good ones by payload.
// ----------------------------------------------------------------------------
// Usage:
//   rx  (sink)   : one received byte per word.
//   pkt (source) : packet words. A good packet (checksum of header and payload
//                  matches, end bytes CR LF) arriving with no run active starts
//                  a run of words, one per payload byte, or one word for an
//                  empty payload; last marks the final word. One run word leaves
//                  per received byte, from the byte that completes the frame.
//   Payload bytes sit in a MAX_PAYLOAD x 8 RAM with registered read.
//   Flow: a byte without a packet word leaves rx.ready high. A byte with a
//   packet word goes through the RAM read (state READ), then the output register
//   (state OUT, pkt.valid high); rx.ready rises at the edge that takes the word.
//   Reset: hunt for the start byte, no run active, pkt.valid low. RAM content
//   is not cleared; a run only reads bytes its own packet wrote.
//   While pkt.ready is low with a word pending, rx.ready stays low.
// ----------------------------------------------------------------------------
module framed_packet_receiver #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic      clk,
  input  logic      rst,
  fpr_rx_if.sink    rx,
  fpr_pkt_if.source pkt
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_ADDR_LO = 4'd1;
  localparam logic [3:0] PH_ADDR_HI = 4'd2;
  localparam logic [3:0] PH_FUNC_LO = 4'd3;
  localparam logic [3:0] PH_FUNC_HI = 4'd4;
  localparam logic [3:0] PH_LEN_LO  = 4'd5;
  localparam logic [3:0] PH_LEN_HI  = 4'd6;
  localparam logic [3:0] PH_DATA    = 4'd7;
  localparam logic [3:0] PH_CHK_LO  = 4'd8;
  localparam logic [3:0] PH_CHK_HI  = 4'd9;
  localparam logic [3:0] PH_END_LO  = 4'd10;
  localparam logic [3:0] PH_END_HI  = 4'd11;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]  state;
  logic [3:0]  phase, phase_next;
  logic [15:0] addr_reg, addr_reg_next;
  logic [15:0] func_reg, func_reg_next;
  logic [15:0] len_reg, len_reg_next;
  logic [6:0]  byte_count, byte_count_next;
  logic [15:0] check_reg, check_reg_next;
  logic [15:0] running_sum, running_sum_next;

  logic                run_on;
  fpr_pkg::addr_t      run_addr;
  fpr_pkg::func_t      run_func;
  fpr_pkg::len_t       run_len;
  logic [6:0]          run_pos;

  logic                in_acc;
  fpr_pkg::byte_t      b;
  logic [15:0]         b16;
  logic                run_start;
  logic                run_act;
  fpr_pkg::len_t       cur_len;
  logic [6:0]          cur_pos;
  logic                fin;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  fpr_pkg::byte_t      rd_data;

  fpr_pkg::addr_t      o_addr;
  fpr_pkg::func_t      o_func;
  fpr_pkg::len_t       o_len;
  logic                o_has;
  fpr_pkg::index_t     o_index;
  fpr_pkg::byte_t      o_byte;
  logic                o_last;

  assign rx.ready = (state == ST_IDLE);
  assign in_acc   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign b16      = {8'h00, b};

  always_comb begin
    phase_next       = phase;
    addr_reg_next    = addr_reg;
    func_reg_next    = func_reg;
    len_reg_next     = len_reg;
    byte_count_next  = byte_count;
    check_reg_next   = check_reg;
    running_sum_next = running_sum;
    case (phase)
      PH_HUNT: begin
        if (b == fpr_pkg::START_BYTE) begin
          phase_next       = PH_ADDR_LO;
          byte_count_next  = 7'd0;
          running_sum_next = 16'd0;
        end
      end
      PH_ADDR_LO: begin
        addr_reg_next    = b16;
        running_sum_next = running_sum + b16;
        phase_next       = PH_ADDR_HI;
      end
      PH_ADDR_HI: begin
        addr_reg_next    = {b, addr_reg[7:0]};
        running_sum_next = running_sum + b16;
        phase_next       = PH_FUNC_LO;
      end
      PH_FUNC_LO: begin
        func_reg_next    = b16;
        running_sum_next = running_sum + b16;
        phase_next       = PH_FUNC_HI;
      end
      PH_FUNC_HI: begin
        func_reg_next    = {b, func_reg[7:0]};
        running_sum_next = running_sum + b16;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_reg_next     = b16;
        running_sum_next = running_sum + b16;
        phase_next       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_reg_next     = {b, len_reg[7:0]};
        running_sum_next = running_sum + b16;
        byte_count_next  = 7'd0;
        if (len_reg_next > 16'(MAX_PAYLOAD)) begin
          phase_next = PH_HUNT;
        end else if (len_reg_next != 16'd0) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_CHK_LO;
        end
      end
      PH_DATA: begin
        running_sum_next = running_sum + b16;
        byte_count_next  = byte_count + 7'd1;
        if ({9'd0, byte_count_next} >= len_reg) begin
          byte_count_next = 7'd0;
          phase_next      = PH_CHK_LO;
        end
      end
      PH_CHK_LO: begin
        check_reg_next = b16;
        phase_next     = PH_CHK_HI;
      end
      PH_CHK_HI: begin
        check_reg_next = {b, check_reg[7:0]};
        phase_next     = PH_END_LO;
      end
      PH_END_LO: begin
        phase_next = (b == fpr_pkg::CR_BYTE) ? PH_END_HI : PH_HUNT;
      end
      PH_END_HI: begin
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign run_start = (phase == PH_END_HI) && (b == fpr_pkg::LF_BYTE) &&
                     (check_reg == running_sum) && !run_on;
  assign run_act   = run_on || run_start;
  assign cur_len   = run_start ? len_reg[6:0] : run_len;
  assign cur_pos   = run_start ? 7'd0 : run_pos;
  assign fin       = (cur_len == 7'd0) || ((cur_pos + 7'd1) >= cur_len);

  assign wr_en   = in_acc && (phase == PH_DATA);
  assign wr_addr = byte_count[AW-1:0];
  assign rd_en   = in_acc && run_act;
  assign rd_addr = cur_pos[AW-1:0];

  fpr_ram #(
    .WIDTH (fpr_pkg::BYTE_W),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (b),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      addr_reg    <= 16'd0;
      func_reg    <= 16'd0;
      len_reg     <= 16'd0;
      byte_count  <= 7'd0;
      check_reg   <= 16'd0;
      running_sum <= 16'd0;
      run_on      <= 1'b0;
      run_addr    <= '0;
      run_func    <= '0;
      run_len     <= '0;
      run_pos     <= 7'd0;
      state       <= ST_IDLE;
    end else begin
      if (in_acc) begin
        phase       <= phase_next;
        addr_reg    <= addr_reg_next;
        func_reg    <= func_reg_next;
        len_reg     <= len_reg_next;
        byte_count  <= byte_count_next;
        check_reg   <= check_reg_next;
        running_sum <= running_sum_next;
        if (run_start) begin
          run_addr <= addr_reg;
          run_func <= func_reg;
          run_len  <= len_reg[6:0];
        end
        if (run_act) begin
          run_on  <= !fin;
          run_pos <= fin ? 7'd0 : (cur_pos + 7'd1);
        end
      end
      case (state)
        ST_IDLE: begin
          if (rd_en) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (pkt.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // capture the word on acceptance, fill in the payload byte after the read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      o_addr  <= run_start ? addr_reg : run_addr;
      o_func  <= run_start ? func_reg : run_func;
      o_len   <= cur_len;
      o_has   <= (cur_len != 7'd0);
      o_index <= (cur_len != 7'd0) ? cur_pos[5:0] : 6'd0;
      o_last  <= fin;
    end
    if (state == ST_READ) begin
      o_byte <= o_has ? rd_data : 8'h00;
    end
  end

  assign pkt.valid         = (state == ST_OUT);
  assign pkt.pkt_address   = o_addr;
  assign pkt.pkt_function  = o_func;
  assign pkt.pkt_length    = o_len;
  assign pkt.has_payload   = o_has;
  assign pkt.payload_index = o_index;
  assign pkt.payload_byte  = o_byte;
  assign pkt.last          = o_last;

  a_read_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> pkt.valid)
    else $error("read did not complete into an output word");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && !pkt.last) |-> run_on)
    else $error("run ended before its last word");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (pkt.valid && !pkt.has_payload) |-> pkt.last)
    else $error("empty packet word not marked last");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("payload write hits the entry being replayed");

endmodule
